// ===== hdl/ialu_pkg.sv =====
// ----------------------------------------------------------------------------
// ialu_pkg: shared types and constants for the integer ALU
// Command codes, sequencer state encoding and the control bundle that the
// sequencer hands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ialu_pkg;

    // Field widths of the transaction ports
    localparam int CMD_W    = 4;
    localparam int RESULT_W = 32;
    localparam int LOW_W    = 16;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_NEG   = 4'd2,
        CMD_INC   = 4'd3,
        CMD_DEC   = 4'd4,
        CMD_SHL   = 4'd5,
        CMD_SAR   = 4'd6,
        CMD_MUL   = 4'd7,
        CMD_SPLIT = 4'd8
    } t_cmd;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_ABSB = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_FIX  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    // Datapath strobes from the sequencer
    typedef struct packed {
        logic load;   // capture an input transaction
        logic exec;   // single-pass ops, or magnitude of A for multiply
        logic absb;   // magnitude of B, clear accumulator
        logic step;   // one shift-and-add iteration
        logic fix;    // apply product sign
    } t_ctrl;

endpackage

`default_nettype wire

// ===== hdl/integer_alu_shift_add_multiply.sv =====
// ----------------------------------------------------------------------------
// integer_alu_shift_add_multiply: two's complement ALU with serial multiplier
// Add, subtract, negate, increment, decrement, shifts, split and a
// sign-magnitude shift-and-add multiply, sharing one adder.
// ----------------------------------------------------------------------------
// One transaction at a time. Add, subtract, negate, increment, decrement,
// shifts, split and unknown commands pass through the EXEC state and show
// their result in OUT. Multiply steps through the magnitude of A, the
// magnitude of B, a shift-and-add step for each bit of B through the shared
// adder, and the sign fix before OUT. o_stall stays high from the accepted
// input until the result transaction is taken, so a new input can be taken
// in the cycle after that. Operands are cut or sign extended to DATA_WIDTH
// bits; results are cut or zero extended to the port widths.
`default_nettype none

module integer_alu_shift_add_multiply
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [CMD_W-1:0]            i_command,
    input  wire logic signed [RESULT_W-1:0]  i_operand_a,
    input  wire logic signed [RESULT_W-1:0]  i_operand_b,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic signed [RESULT_W-1:0]       o_result,
    output logic [LOW_W-1:0]                 o_low_half
);

    t_ctrl ctrl;
    logic  is_mul;
    logic  busy;
    logic  accept;

    assign accept  = i_valid && !busy;
    assign o_stall = busy;

    // Sequencer
    ialu_seq #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_is_mul    (is_mul),
        .i_out_stall (i_stall),
        .o_ctrl      (ctrl),
        .o_busy      (busy),
        .o_out_valid (o_valid)
    );

    // Datapath
    ialu_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_ctrl      (ctrl),
        .i_command   (i_command),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_is_mul    (is_mul),
        .o_result    (o_result),
        .o_low_half  (o_low_half)
    );

`ifndef NO_ASSERTIONS
    // A pending result keeps the input side closed
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while a result is pending");

    // An accepted transaction closes the input side
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_stall && !o_valid))
        else $error("input not closed after accept");

    // A delivered result is not repeated
    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_valid)
        else $error("result repeated after delivery");
`endif

endmodule

`default_nettype wire

// ===== hdl/ialu_seq.sv =====
// ----------------------------------------------------------------------------
// ialu_seq: sequencer for the integer ALU
// Steps the shared adder through setup, the shift-and-add loop and the sign
// fix, and runs both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module ialu_seq
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_accept,
    input  wire logic i_is_mul,
    input  wire logic i_out_stall,
    output t_ctrl     o_ctrl,
    output logic      o_busy,
    output logic      o_out_valid
);

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_is_mul ? ST_ABSB : ST_OUT;
            end
            ST_ABSB: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_cnt == LAST_STEP) n_state = ST_FIX;
            end
            ST_FIX: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and iteration count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MUL) r_cnt <= r_cnt + CNT_W'(1);
            else                   r_cnt <= '0;
        end
    end

    // Decode strobes
    assign o_ctrl.load  = (r_state == ST_IDLE) && i_accept;
    assign o_ctrl.exec  = (r_state == ST_EXEC);
    assign o_ctrl.absb  = (r_state == ST_ABSB);
    assign o_ctrl.step  = (r_state == ST_MUL);
    assign o_ctrl.fix   = (r_state == ST_FIX);
    assign o_busy       = (r_state != ST_IDLE);
    assign o_out_valid  = (r_state == ST_OUT);

`ifndef NO_ASSERTIONS
    // Counter runs only inside the multiply loop
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_MUL) |=> (r_cnt == '0))
        else $error("iteration counter not cleared outside loop");

    // Loop always ends in the sign fix after the last step
    a_loop_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_cnt == LAST_STEP) |=> (r_state == ST_FIX))
        else $error("multiply loop did not end on the last step");

    // Multiply loop always follows the magnitude of B, with a cleared counter
    a_absb_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ABSB) |=> (r_state == ST_MUL && r_cnt == '0))
        else $error("loop entered without a cleared counter");
`endif

endmodule

`default_nettype wire

// ===== hdl/ialu_dp.sv =====
// ----------------------------------------------------------------------------
// ialu_dp: datapath for the integer ALU
// Operand and accumulator registers around one shared adder/subtractor and a
// barrel shifter. Multiply runs one bit of B per pass through the adder.
// ----------------------------------------------------------------------------
`default_nettype none

module ialu_dp
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire t_ctrl                       i_ctrl,
    input  wire logic [CMD_W-1:0]            i_command,
    input  wire logic signed [RESULT_W-1:0]  i_operand_a,
    input  wire logic signed [RESULT_W-1:0]  i_operand_b,
    output logic                             o_is_mul,
    output logic signed [RESULT_W-1:0]       o_result,
    output logic [LOW_W-1:0]                 o_low_half
);

    localparam int W     = DATA_WIDTH;
    localparam int HALF  = DATA_WIDTH / 2;
    localparam int SH_W  = $clog2(DATA_WIDTH);
    localparam logic [W-1:0] WIDTH_VAL = W'(DATA_WIDTH);

    logic [CMD_W-1:0] r_cmd;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_res;
    logic [HALF-1:0]  r_lo;
    logic             r_neg;

    logic [W-1:0]     add_x;
    logic [W-1:0]     add_y;
    logic             add_inv;
    logic [W-1:0]     add_sum;
    logic [SH_W-1:0]  sh_amt;
    logic             sh_big;
    logic [W-1:0]     shl_val;
    logic [W-1:0]     sar_val;
    logic [W-1:0]     exec_val;

    // Select adder operands
    always_comb begin
        add_x   = r_a;
        add_y   = r_b;
        add_inv = 1'b0;
        if (i_ctrl.exec) begin
            case (r_cmd)
                CMD_SUB: begin
                    add_inv = 1'b1;
                end
                CMD_NEG: begin
                    add_x   = '0;
                    add_y   = r_a;
                    add_inv = 1'b1;
                end
                CMD_INC: begin
                    add_y = W'(1);
                end
                CMD_DEC: begin
                    add_y = W'(1);
                    add_inv = 1'b1;
                end
                CMD_MUL: begin
                    add_x   = '0;
                    add_y   = r_a;
                    add_inv = r_a[W-1];
                end
                default: begin
                    add_x = r_a;
                end
            endcase
        end else if (i_ctrl.absb) begin
            add_x   = '0;
            add_y   = r_b;
            add_inv = r_b[W-1];
        end else if (i_ctrl.step) begin
            add_x = r_acc;
            add_y = r_b[0] ? r_a : '0;
        end else if (i_ctrl.fix) begin
            add_x   = '0;
            add_y   = r_acc;
            add_inv = r_neg;
        end
    end

    // Shared adder: x + y, or x - y through invert and carry in
    assign add_sum = add_x + (add_y ^ {W{add_inv}}) + W'(add_inv);

    // Barrel shifter, amount read as unsigned
    assign sh_amt  = r_b[SH_W-1:0];
    assign sh_big  = (r_b >= WIDTH_VAL);
    assign shl_val = sh_big ? '0 : (r_a << sh_amt);
    assign sar_val = sh_big ? {W{r_a[W-1]}} : W'($signed(r_a) >>> sh_amt);

    // Pick the single-pass result
    always_comb begin
        case (r_cmd) inside
            CMD_ADD, CMD_SUB, CMD_NEG, CMD_INC, CMD_DEC: exec_val = add_sum;
            CMD_SHL:   exec_val = shl_val;
            CMD_SAR:   exec_val = sar_val;
            CMD_SPLIT: exec_val = {r_a[W-1:HALF], HALF'(0)};
            default:   exec_val = '0;
        endcase
    end

    // Advance operand, accumulator and result registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_command;
            r_a   <= W'(i_operand_a);
            r_b   <= W'(i_operand_b);
        end else if (i_ctrl.exec) begin
            if (r_cmd == CMD_MUL) begin
                r_a   <= add_sum;
                r_neg <= r_a[W-1] ^ r_b[W-1];
            end else begin
                r_res <= exec_val;
                r_lo  <= (r_cmd == CMD_SPLIT) ? r_a[HALF-1:0] : '0;
            end
        end else if (i_ctrl.absb) begin
            r_b   <= add_sum;
            r_acc <= '0;
        end else if (i_ctrl.step) begin
            r_acc <= add_sum;
            r_a   <= {r_a[W-2:0], 1'b0};
            r_b   <= {1'b0, r_b[W-1:1]};
        end else if (i_ctrl.fix) begin
            r_res <= add_sum;
            r_lo  <= '0;
        end
    end

    assign o_is_mul   = (r_cmd == CMD_MUL);
    assign o_result   = RESULT_W'(r_res);
    assign o_low_half = LOW_W'(r_lo);

endmodule

`default_nettype wire
